FILE: sv/s38i_pkg.sv
// Shared types and constants for the Simpson 3/8 integrator.
package s38i_pkg;

  // Payload widths
  localparam int unsigned BoundW = 24;
  localparam int unsigned CountW = 13;
  localparam int unsigned AreaW  = 27;

  // Shared divider geometry
  localparam int unsigned DivW    = 64;
  localparam int unsigned DivQW   = 27;
  localparam int unsigned DivCntW = 5;

  // Saturation limits of the Q2.24 result
  localparam logic signed [AreaW-1:0] AreaMax = {1'b0, {(AreaW-1){1'b1}}};
  localparam logic signed [AreaW-1:0] AreaMin = {1'b1, {(AreaW-1){1'b0}}};

  typedef struct packed {
    logic signed [BoundW-1:0] lower_bound;
    logic signed [BoundW-1:0] upper_bound;
    logic [CountW-1:0]        interval_count;
  } in_item_t;

  typedef struct packed {
    logic signed [AreaW-1:0] area;
    logic                    bad_count;
  } out_item_t;

  // Which division the shared divider runs
  typedef enum logic [1:0] {
    DIV_N,
    DIV_F,
    DIV_A
  } div_sel_e;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_e div_sel;
    logic     save_step;
    logic     square;
    logic     accum;
    logic     mul_lo;
    logic     mul_hi;
    logic     publish;
    logic     pub_zero;
  } cmd_t;

  typedef struct packed {
    logic zero_count;
    logic more_samples;
    logic div_busy;
  } sts_t;

endpackage

FILE: sv/s38i_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions.
module s38i_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [s38i_pkg::DivW-1:0]           rem_init_i,
  input  logic [s38i_pkg::DivQW-1:0]          lo_init_i,
  input  logic [s38i_pkg::DivW-1:0]           divisor_i,
  input  logic [s38i_pkg::DivCntW-1:0]        steps_i,
  output logic                                busy_o,
  output logic [s38i_pkg::DivQW-1:0]          quo_o,
  output logic [s38i_pkg::DivW-1:0]           rem_o
);

  logic                                busy_q;
  logic [s38i_pkg::DivCntW-1:0]        cnt_q;
  logic [s38i_pkg::DivW-1:0]           rem_q, div_q, rem_d;
  logic [s38i_pkg::DivQW-1:0]          lo_q, quo_q;
  logic [s38i_pkg::DivW:0]             trial;
  logic                                fits;

  // Shift in one dividend bit and try to subtract
  always_comb begin
    trial = {rem_q, lo_q[s38i_pkg::DivQW-1]};
    fits  = trial >= {1'b0, div_q};
    rem_d = fits ? s38i_pkg::DivW'(trial - {1'b0, div_q}) : trial[s38i_pkg::DivW-1:0];
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == s38i_pkg::DivCntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Operands and partial results
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_init_i;
      lo_q  <= lo_init_i;
      div_q <= divisor_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      lo_q  <= {lo_q[s38i_pkg::DivQW-2:0], 1'b0};
      quo_q <= {quo_q[s38i_pkg::DivQW-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

FILE: sv/s38i_dp.sv
// Datapath: sample stepping, f(x) evaluation, weighted sum and final scaling.
module s38i_dp #(
  parameter int unsigned MAX_INTERVALS = 4096,
  parameter int unsigned FRAC_BITS     = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  s38i_pkg::in_item_t   in_data_i,
  input  s38i_pkg::cmd_t       cmd_i,
  output s38i_pkg::sts_t       sts_o,
  output s38i_pkg::out_item_t  out_data_o
);

  localparam int unsigned SqShr = (2 * FRAC_BITS >= 32) ? 2 * FRAC_BITS - 32 : 0;
  localparam int unsigned SqShl = (2 * FRAC_BITS < 32) ? 32 - 2 * FRAC_BITS : 0;
  localparam int unsigned DShift = FRAC_BITS + 3;

  typedef enum logic [1:0] {
    K_LO,
    K_HI,
    K_MID
  } kind_e;

  logic signed [23:0] a_q, b_q;
  logic [12:0]        n_q;
  logic               neg_q;
  logic [24:0]        dm_q;
  logic [24:0]        stepq_q, accq_q;
  logic [12:0]        stepr_q, accr_q;
  logic [12:0]        idx_q;
  logic [1:0]         mod3_q;
  kind_e              kind_q;
  logic signed [24:0] x_q;
  logic [63:0]        den_q;
  logic [39:0]        sum_q;
  logic [65:0]        prod_q;
  logic               ovf_q;
  s38i_pkg::out_item_t out_q;

  // Input decode
  logic signed [24:0] diff;
  logic [12:0]        n_clamp;
  always_comb begin
    diff = {in_data_i.upper_bound[23], in_data_i.upper_bound}
         - {in_data_i.lower_bound[23], in_data_i.lower_bound};
    if (32'(in_data_i.interval_count) > MAX_INTERVALS) begin
      n_clamp = 13'(MAX_INTERVALS);
    end else begin
      n_clamp = in_data_i.interval_count;
    end
  end

  // Divider operand selection
  logic [63:0] numer_f, d_area, div_rem_init, div_divisor, div_rem;
  logic [26:0] div_lo, div_quo;
  logic [4:0]  div_steps;
  logic        div_busy;
  always_comb begin
    numer_f = (64'd1 << 56) + (den_q >> 1);
    d_area  = 64'(n_q) << DShift;
    case (cmd_i.div_sel)
      s38i_pkg::DIV_N: begin
        div_rem_init = '0;
        div_lo       = {dm_q, 2'b00};
        div_divisor  = 64'(n_q);
        div_steps    = 5'd25;
      end
      s38i_pkg::DIV_F: begin
        div_rem_init = numer_f >> 25;
        div_lo       = {numer_f[24:0], 2'b00};
        div_divisor  = den_q;
        div_steps    = 5'd25;
      end
      s38i_pkg::DIV_A: begin
        div_rem_init = 64'(prod_q >> 27);
        div_lo       = prod_q[26:0];
        div_divisor  = d_area;
        div_steps    = 5'd27;
      end
      default: begin
        div_rem_init = '0;
        div_lo       = '0;
        div_divisor  = 64'd1;
        div_steps    = 5'd1;
      end
    endcase
  end

  s38i_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .rem_init_i (div_rem_init),
    .lo_init_i  (div_lo),
    .divisor_i  (div_divisor),
    .steps_i    (div_steps),
    .busy_o     (div_busy),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // Squaring for the denominator 1 + x*x in Q.32
  logic [24:0] x_mag;
  logic [47:0] sq;
  always_comb begin
    x_mag = x_q[24] ? 25'(-x_q) : 25'(x_q);
    sq    = x_mag[23:0] * x_mag[23:0];
  end

  // Weighted sample and next interior point
  logic [24:0] f_val;
  logic [26:0] wf;
  logic [13:0] racc_sum;
  logic        carry;
  logic [24:0] q_next;
  logic signed [25:0] x_next;
  always_comb begin
    f_val = div_quo[24:0];
    if (kind_q != K_MID) begin
      wf = 27'(f_val);
    end else if (mod3_q == 2'd0) begin
      wf = 27'(f_val) << 1;
    end else begin
      wf = 27'(f_val) + (27'(f_val) << 1);
    end
    racc_sum = 14'(accr_q) + 14'(stepr_q);
    carry    = racc_sum >= 14'(n_q);
    q_next   = accq_q + stepq_q + 25'(carry);
    x_next   = neg_q ? 26'(a_q) - 26'(q_next) : 26'(a_q) + 26'(q_next);
  end

  // Final scaling: multiplier 3*|b-a| and rounded quotient
  logic [25:0] tm;
  logic [27:0] q_round;
  logic signed [26:0] area_res;
  always_comb begin
    tm      = 26'(dm_q) + (26'(dm_q) << 1);
    q_round = 28'(div_quo) + 28'({div_rem, 1'b0} >= {1'b0, d_area});
    if (neg_q) begin
      area_res = (ovf_q || q_round > 28'(67108864)) ? s38i_pkg::AreaMin : 27'(-q_round);
    end else begin
      area_res = (ovf_q || q_round > 28'(s38i_pkg::AreaMax)) ? s38i_pkg::AreaMax
                                                             : 27'(q_round);
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q   <= in_data_i.lower_bound;
      b_q   <= in_data_i.upper_bound;
      n_q   <= n_clamp;
      neg_q <= diff[24];
      dm_q  <= diff[24] ? 25'(-diff) : 25'(diff);
    end
    if (cmd_i.save_step) begin
      stepq_q <= div_quo[24:0];
      stepr_q <= div_rem[12:0];
      accq_q  <= '0;
      accr_q  <= '0;
      idx_q   <= '0;
      mod3_q  <= '0;
      kind_q  <= K_LO;
      x_q     <= 25'(a_q);
      sum_q   <= '0;
    end
    if (cmd_i.square) begin
      den_q <= (64'd1 << 32) + ((64'(sq) << SqShl) >> SqShr);
    end
    if (cmd_i.accum) begin
      sum_q <= sum_q + 40'(wf);
      case (kind_q)
        K_LO: begin
          kind_q <= K_HI;
          x_q    <= 25'(b_q);
        end
        K_HI, K_MID: begin
          kind_q <= K_MID;
          accr_q <= carry ? 13'(racc_sum - 14'(n_q)) : 13'(racc_sum);
          accq_q <= q_next;
          x_q    <= 25'(x_next);
          idx_q  <= idx_q + 1'b1;
          mod3_q <= (mod3_q == 2'd2) ? 2'd0 : mod3_q + 1'b1;
        end
        default: kind_q <= K_LO;
      endcase
    end
    if (cmd_i.mul_lo) begin
      prod_q <= 66'(tm * sum_q[19:0]);
    end
    if (cmd_i.mul_hi) begin
      prod_q <= prod_q + (66'(tm * sum_q[39:20]) << 20);
    end
    if (cmd_i.div_start && cmd_i.div_sel == s38i_pkg::DIV_A) begin
      ovf_q <= 64'(prod_q >> 27) >= d_area;
    end
    if (cmd_i.publish) begin
      if (cmd_i.pub_zero) begin
        out_q.area      <= '0;
        out_q.bad_count <= 1'b1;
      end else begin
        out_q.area      <= area_res;
        out_q.bad_count <= 1'b0;
      end
    end
  end

  // Status back to the controller
  always_comb begin
    sts_o.zero_count = in_data_i.interval_count == '0;
    sts_o.div_busy   = div_busy;
    case (kind_q)
      K_LO:    sts_o.more_samples = 1'b1;
      K_HI:    sts_o.more_samples = n_q > 13'd1;
      K_MID:   sts_o.more_samples = (14'(idx_q) + 14'd1) < 14'(n_q);
      default: sts_o.more_samples = 1'b0;
    endcase
  end

  assign out_data_o = out_q;

endmodule

FILE: sv/s38i_ctrl.sv
// Controller: sequences one job through the datapath and owns the handshakes.
module s38i_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  s38i_pkg::sts_t sts_i,
  output s38i_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIVN,
    S_DIVN_RUN,
    S_SQ,
    S_DIVF,
    S_DIVF_RUN,
    S_ACC,
    S_MUL_LO,
    S_MUL_HI,
    S_DIVA,
    S_DIVA_RUN,
    S_PUB,
    S_ZERO
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = state_q == S_IDLE;

  // Commands and next state
  always_comb begin
    cmd_o       = '0;
    cmd_o.div_sel = s38i_pkg::DIV_N;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.zero_count ? S_ZERO : S_DIVN;
        end
      end
      S_DIVN: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIVN_RUN;
      end
      S_DIVN_RUN: begin
        if (!sts_i.div_busy) begin
          cmd_o.save_step = 1'b1;
          state_d         = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.square = 1'b1;
        state_d      = S_DIVF;
      end
      S_DIVF: begin
        cmd_o.div_sel   = s38i_pkg::DIV_F;
        cmd_o.div_start = 1'b1;
        state_d         = S_DIVF_RUN;
      end
      S_DIVF_RUN: begin
        cmd_o.div_sel = s38i_pkg::DIV_F;
        if (!sts_i.div_busy) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.accum = 1'b1;
        state_d     = sts_i.more_samples ? S_SQ : S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = S_DIVA;
      end
      S_DIVA: begin
        cmd_o.div_sel   = s38i_pkg::DIV_A;
        cmd_o.div_start = 1'b1;
        state_d         = S_DIVA_RUN;
      end
      S_DIVA_RUN: begin
        cmd_o.div_sel = s38i_pkg::DIV_A;
        if (!sts_i.div_busy) begin
          state_d = S_PUB;
        end
      end
      S_PUB: begin
        cmd_o.div_sel = s38i_pkg::DIV_A;
        if (slot_free) begin
          cmd_o.publish = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_ZERO: begin
        if (slot_free) begin
          cmd_o.publish  = 1'b1;
          cmd_o.pub_zero = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A result is only written into a free output slot
  a_pub_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> slot_free)
    else $error("result published over a pending transaction");

  // One job at a time
  a_one_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while a job is running");

  // Divider never restarted while busy
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !sts_i.div_busy)
    else $error("divider started while busy");

  // Divider only runs in a wait state
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_busy |-> (state_q == S_DIVN_RUN || state_q == S_DIVF_RUN ||
                        state_q == S_DIVA_RUN))
    else $error("divider busy outside a wait state");

endmodule

FILE: sv/simpson_three_eighths_integrator.sv
// Top level of the Simpson 3/8 integrator of f(x) = 1/(1+x*x).
//
//   channel | signals                        | payload
//   input   | in_valid_i / in_ready_o        | in_data_i  (lower_bound, upper_bound, count)
//   output  | out_valid_o / out_ready_i      | out_data_o (area, bad_count)
//
// Each sample of a job with count n (clamped) needs a squaring step, a divider
// start, a pass of the shared radix-2 divider, a step to see it done and one
// accumulate step. No clearing pass after reset.
// One job runs at a time; a finished result waits in the output register
// while the next job is accepted, and a job stalls only to publish its result.
module simpson_three_eighths_integrator #(
  parameter int unsigned MAX_INTERVALS = 4096,
  parameter int unsigned FRAC_BITS     = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  s38i_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output s38i_pkg::out_item_t out_data_o
);

  s38i_pkg::cmd_t cmd;
  s38i_pkg::sts_t sts;

  s38i_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  s38i_dp #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .FRAC_BITS     (FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule
